// ===== rtl/erm_pkg.sv =====
// Package with constants, types and tone tables for the echo ranging median block.
package erm_pkg;

  localparam int unsigned WindowSizeDef = 7;
  localparam int unsigned StampWidthDef = 16;

  localparam int unsigned DistW   = 9;
  localparam int unsigned PeriodW = 14;
  localparam int unsigned HighW   = 13;
  localparam int unsigned SelW    = 3;

  localparam logic [DistW-1:0] DistMin = 9'd2;
  localparam logic [DistW-1:0] DistMax = 9'd400;

  // An echo of at least 401 * 58 timer ticks clamps to the maximum distance.
  localparam logic [31:0] DeltaOver = 32'd23258;

  // Reciprocal of 58 scaled by 2^21, exact for every delta below DeltaOver.
  localparam int unsigned     RecipShift = 21;
  localparam logic [15:0]     RecipMul   = 16'd36158;
  localparam int unsigned     DeltaLowW  = 15;

  localparam logic [SelW-1:0] ToneCount = 3'd5;

  typedef struct packed {
    logic [DistW-1:0] value;
    logic             shift;
  } erm_link_t;

  function automatic logic [DistW-1:0] tone_dist(input logic [SelW-1:0] sel);
    logic [DistW-1:0] d;
    unique case (sel)
      3'd0:    d = 9'd5;
      3'd1:    d = 9'd20;
      3'd2:    d = 9'd50;
      3'd3:    d = 9'd90;
      3'd4:    d = 9'd200;
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [PeriodW-1:0] tone_period(input logic [SelW-1:0] sel);
    logic [PeriodW-1:0] p;
    unique case (sel)
      3'd0:    p = 14'd333;
      3'd1:    p = 14'd500;
      3'd2:    p = 14'd1000;
      3'd3:    p = 14'd2000;
      3'd4:    p = 14'd10000;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [HighW-1:0] tone_high(input logic [SelW-1:0] sel);
    logic [HighW-1:0] h;
    unique case (sel)
      3'd0:    h = 13'd166;
      3'd1:    h = 13'd250;
      3'd2:    h = 13'd500;
      3'd3:    h = 13'd1000;
      3'd4:    h = 13'd5000;
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/erm_dist.sv =====
// Echo time to clamped centimetre distance through a reciprocal multiply.
module erm_dist #(
  parameter int unsigned StampWidth = erm_pkg::StampWidthDef
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [StampWidth-1:0]      delta_i,
  output logic [erm_pkg::DistW-1:0]  dist_o
);
  import erm_pkg::*;

  localparam int unsigned ProdW = DeltaLowW + 16;

  logic [31:0]          delta_ext;
  logic [DeltaLowW-1:0] delta_low;
  logic [ProdW-1:0]     prod;
  logic [DistW-1:0]     quot;
  logic [DistW-1:0]     dist_d, dist_q;

  assign delta_ext = 32'(delta_i);
  assign delta_low = delta_ext[DeltaLowW-1:0];
  assign prod      = ProdW'(delta_low) * ProdW'(RecipMul);
  assign quot      = prod[RecipShift +: DistW];

  always_comb begin
    if (delta_ext >= DeltaOver) begin
      dist_d = DistMax;
    end else if (quot < DistMin) begin
      dist_d = DistMin;
    end else begin
      dist_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

// ===== rtl/erm_cell.sv =====
// One cell of the sorted insertion chain holding a single window sample.
module erm_cell (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       valid_i,
  input  logic [erm_pkg::DistW-1:0]  sample_i,
  input  erm_pkg::erm_link_t         left_i,
  output erm_pkg::erm_link_t         right_o,
  output logic [erm_pkg::DistW-1:0]  value_o
);
  import erm_pkg::*;

  logic [DistW-1:0] val_d, val_q;
  logic             shift;

  // An empty cell behaves as larger than any sample.
  assign shift = !valid_i || (sample_i < val_q);

  always_comb begin
    if (!shift) begin
      val_d = val_q;
    end else if (left_i.shift) begin
      val_d = left_i.value;
    end else begin
      val_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= val_d;
    end
  end

  assign right_o.value = val_q;
  assign right_o.shift = shift;
  assign value_o       = val_q;

endmodule

// ===== rtl/echo_range_median_tone_select_top.sv =====
// Top level of the echo ranging block with median-of-window filter and tone select.
//
// Input words carry one echo edge: s_axis_tuser is the edge kind (0 rising,
// 1 falling) and s_axis_tdata the captured timer stamp. A rising edge stores
// the start stamp. A falling edge converts the stamp difference to a clamped
// distance in centimetres and inserts it into a sorted chain of cells.
// When the window fills, one output word gives the median distance and the
// tone decision for the tone chosen through cfg_wdata_i.
// A falling edge passes through the delta, the reciprocal multiply and the
// insertion into the cell chain. The falling edge that fills the window
// then takes a median and tone lookup step that loads the output register.
// One edge is in work at a time: no new edge is taken until a falling edge
// has finished its steps and the block is idle again.
// The output word sits in a register, so a new edge is taken while the
// receiver stalls; only the lookup step waits for the register to empty.
// Reset clears the start stamp, the window fill count, the tone select and
// the output valid flag.
module echo_range_median_tone_select_top #(
  parameter int unsigned WindowSize = erm_pkg::WindowSizeDef,
  parameter int unsigned StampWidth = erm_pkg::StampWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [erm_pkg::SelW-1:0]         cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // capture_time
  input  logic [((StampWidth+7)/8)*8-1:0]  s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // median_distance, tone_period, tone_high_time, zero fill
  output logic [39:0]                      m_axis_tdata,
  // tone_on
  output logic                             m_axis_tuser
);
  import erm_pkg::*;

  localparam int unsigned CntW  = (WindowSize > 1) ? $clog2(WindowSize) : 1;
  localparam int unsigned OutW  = DistW + PeriodW + HighW;
  localparam int unsigned PadW  = 40 - OutW;
  localparam int unsigned MedIx = WindowSize / 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_INS  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e               state_d, state_q;
  logic [SelW-1:0]      sel_q;
  logic [StampWidth-1:0] start_q, delta_q, stamp;
  logic [CntW-1:0]      cnt_d, cnt_q;
  logic [DistW-1:0]     dist_cm;
  logic                 in_acc, out_free;
  logic                 ov_d, ov_q;
  logic [39:0]          od_d, od_q;
  logic                 ou_d, ou_q;
  logic [DistW-1:0]     med;
  logic                 tone_hit;

  erm_link_t            link [WindowSize+1];
  logic [DistW-1:0]     cell_val [WindowSize];

  assign stamp         = s_axis_tdata[StampWidth-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  erm_dist #(
    .StampWidth(StampWidth)
  ) u_dist (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_CALC),
    .delta_i(delta_q),
    .dist_o (dist_cm)
  );

  assign link[0].value = '0;
  assign link[0].shift = 1'b0;

  for (genvar k = 0; k < WindowSize; k++) begin : g_cell
    erm_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (state_q == ST_INS),
      .valid_i (cnt_q > CntW'(k)),
      .sample_i(dist_cm),
      .left_i  (link[k]),
      .right_o (link[k+1]),
      .value_o (cell_val[k])
    );
  end

  assign med      = cell_val[MedIx];
  assign tone_hit = (sel_q < ToneCount) && (med == tone_dist(sel_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !m_axis_tready;
    od_d    = od_q;
    ou_d    = ou_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_INS;
      end
      ST_INS: begin
        if (cnt_q == CntW'(WindowSize - 1)) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cnt_d   = '0;
          ov_d    = 1'b1;
          ou_d    = tone_hit;
          od_d    = {PadW'(0),
                     tone_hit ? tone_high(sel_q) : HighW'(0),
                     tone_hit ? tone_period(sel_q) : PeriodW'(0),
                     med};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      if (in_acc && !s_axis_tuser) begin
        start_q <= stamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    ou_q <= ou_d;
    if (in_acc && s_axis_tuser) begin
      delta_q <= stamp - start_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

endmodule
